/* src/float_block_residual_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the block float residual decoder
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef FLOAT_BLOCK_RESIDUAL_DECODER_UNIT_ASSERT_SVH
`define FLOAT_BLOCK_RESIDUAL_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FBRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FBRD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fbrd_pkg.sv */
// ----------------------------------------------------------------------------
// Block float residual decoder package
// Sequencer states, request codes and fixed format constants.
// ----------------------------------------------------------------------------
package fbrd_pkg;

    localparam logic        REQ_LOAD     = 1'b0;
    localparam logic        REQ_EMIT     = 1'b1;
    localparam int unsigned HEADER_BYTES = 5;
    localparam logic [1:0]  LEAD_MASK    = 2'h3;
    localparam int unsigned BYTE_BITS    = 8;
    localparam logic [31:0] QNAN_BITS    = 32'hFFC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR,
        S_RES,
        S_RESD,
        S_ADD,
        S_ALIGN,
        S_SUM,
        S_NORM,
        S_RND,
        S_DONE
    } t_state;

endpackage

/* src/fbrd_in_if.sv */
// ----------------------------------------------------------------------------
// Decoder request channel
// Valid/ready channel carrying load and emit requests.
// ----------------------------------------------------------------------------
interface fbrd_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic       start_req;
    logic [7:0] block_len;
    logic [7:0] data_byte;

    modport source(output valid, req_type, start_req, block_len, data_byte, input ready);
    modport sink(input valid, req_type, start_req, block_len, data_byte, output ready);
endinterface

/* src/fbrd_out_if.sv */
// ----------------------------------------------------------------------------
// Decoder result channel
// Valid/ready channel carrying decoded single-precision values.
// ----------------------------------------------------------------------------
interface fbrd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_bits;
    logic        last;

    modport source(output valid, value_bits, last, input ready);
    modport sink(input valid, value_bits, last, output ready);
endinterface

/* src/float_block_residual_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Block float residual decoder
// Stores compressed bytes of one block and decodes its elements one at a
// time through a single-port byte store and a multi-cycle float adder.
//
//   channel | dir | transfer
//   i_in    | in  | load byte (req_type 0) or emit next element (req_type 1)
//   o_out   | out | decoded value bits and last flag
//
// A load writes its byte to the store in the transfer cycle. An emit reads the
// header, then each residual byte (0 to 4), then adds: special operands skip
// align, sum, normalize and round. The result is handed off once the previous
// one is taken. The store has one read port; normalize shifts one bit per cycle.
// Reset is synchronous and clears all control state; the store is not cleared.
// A waiting result does not block loads; the next result waits for its slot.
// ----------------------------------------------------------------------------
module float_block_residual_decoder_unit #(
    parameter int unsigned BLOCK_MAX   = 128,
    parameter int unsigned STORE_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbrd_in_if.sink     i_in,
    fbrd_out_if.source  o_out
);

    localparam int unsigned AW = $clog2(STORE_BYTES);
    localparam int unsigned PW = ((AW > 7) ? AW : 7) + 1;

    fbrd_pkg::t_state r_state, n_state;

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rdata;
    logic [2:0]    r_step;
    logic [AW-1:0] r_wp, r_rp;
    logic [7:0]    r_idx, r_len;
    logic [31:0]   r_prev, r_med, r_word, r_res;
    logic [7:0]    r_req;
    logic [2:0]    r_shift, r_copy;
    logic [1:0]    r_byte;
    logic          r_sgn, r_sub;
    logic [7:0]    r_exp, r_d;
    logic [23:0]   r_ma, r_mb;
    logic [27:0]   r_bal, r_sum;
    logic          r_ovalid, r_olast;
    logic [31:0]   r_oval;

    logic          in_xfer, is_load, is_emit, mem_we;
    logic [AW-1:0] wr_addr, wr_next, rp_next, rd_addr;
    logic [PW-1:0] lead_addr, rp_init;
    logic [7:0]    len_sat;
    logic [5:0]    nb_raw;
    logic [2:0]    hdr_n, hdr_shift, hdr_copy;
    logic [1:0]    hdr_lead;
    logic [31:0]   copy_mask;
    logic [31:0]   wsh, op_a, op_b, big, little, spec_res;
    logic          spec;
    logic [7:0]    ea, eb;
    logic [26:0]   b_ext, b_shf, b_msk;
    logic [27:0]   a_ext;
    logic [7:0]    e_field;
    logic          rnd_inc;
    logic [31:0]   rnd_comb;
    logic          out_free;

    assign i_in.ready       = (r_state == fbrd_pkg::S_IDLE);
    assign in_xfer          = i_in.valid && i_in.ready;
    assign is_load          = in_xfer && (i_in.req_type == fbrd_pkg::REQ_LOAD);
    assign is_emit          = in_xfer && (i_in.req_type == fbrd_pkg::REQ_EMIT);
    assign mem_we           = is_load;
    assign o_out.valid      = r_ovalid;
    assign o_out.value_bits = r_oval;
    assign o_out.last       = r_olast;
    assign out_free         = !r_ovalid || o_out.ready;

    assign wr_addr = i_in.start_req ? '0 : r_wp;
    assign wr_next = (({1'b0, wr_addr} + 1'b1) == (AW+1)'(STORE_BYTES))
                   ? '0 : wr_addr + 1'b1;
    assign rp_next = (({1'b0, r_rp} + 1'b1) == (AW+1)'(STORE_BYTES))
                   ? '0 : r_rp + 1'b1;

    assign len_sat = (32'(i_in.block_len) > BLOCK_MAX) ? 8'(BLOCK_MAX) : i_in.block_len;

    always_comb begin
        logic [8:0] len3;
        logic [PW-1:0] v;
        logic [PW-1:0] la;
        len3 = {1'b0, len_sat} + 9'd3;
        v = PW'(fbrd_pkg::HEADER_BYTES) + PW'(len3[8:2]);
        rp_init = (v >= PW'(STORE_BYTES)) ? v - PW'(STORE_BYTES) : v;
        la = PW'(fbrd_pkg::HEADER_BYTES) + PW'(r_idx[7:2]);
        lead_addr = (la >= PW'(STORE_BYTES)) ? la - PW'(STORE_BYTES) : la;
    end

    always_comb begin
        unique case (r_state)
            fbrd_pkg::S_HDR: rd_addr = (r_step < 3'd5) ? AW'(r_step) : lead_addr[AW-1:0];
            fbrd_pkg::S_RES: rd_addr = r_rp;
            default:         rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_in.data_byte;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Header decode, valid in the last header read cycle.
    always_comb begin
        nb_raw    = {1'b0, r_req[7:3]} + {5'd0, (r_req[2:0] != 3'd0)};
        hdr_n     = (nb_raw >= 6'd1 && nb_raw <= 6'd3) ? nb_raw[2:0] : 3'd4;
        hdr_shift = (r_req[2:0] != 3'd0) ? 3'(4'd8 - {1'b0, r_req[2:0]}) : 3'd0;
        case (r_idx[1:0])
            2'd0:    hdr_lead = r_rdata[7:6] & fbrd_pkg::LEAD_MASK;
            2'd1:    hdr_lead = r_rdata[5:4] & fbrd_pkg::LEAD_MASK;
            2'd2:    hdr_lead = r_rdata[3:2] & fbrd_pkg::LEAD_MASK;
            default: hdr_lead = r_rdata[1:0] & fbrd_pkg::LEAD_MASK;
        endcase
        hdr_copy = ({1'b0, hdr_lead} < hdr_n) ? {1'b0, hdr_lead} : hdr_n;
        case (hdr_copy)
            3'd0:    copy_mask = 32'h0000_0000;
            3'd1:    copy_mask = 32'hFF00_0000;
            3'd2:    copy_mask = 32'hFFFF_0000;
            3'd3:    copy_mask = 32'hFFFF_FF00;
            default: copy_mask = 32'hFFFF_FFFF;
        endcase
    end

    // Operand unpack and special values.
    always_comb begin
        wsh   = r_word << r_shift;
        op_a  = wsh;
        op_b  = r_med;
        spec  = 1'b1;
        if (op_a[30:23] == 8'hFF && op_a[22:0] != '0) begin
            spec_res = op_a | fbrd_pkg::QUIET_BIT;
        end else if (op_b[30:23] == 8'hFF && op_b[22:0] != '0) begin
            spec_res = op_b | fbrd_pkg::QUIET_BIT;
        end else if (op_a[30:23] == 8'hFF && op_b[30:23] == 8'hFF && op_a[31] != op_b[31]) begin
            spec_res = fbrd_pkg::QNAN_BITS;
        end else if (op_a[30:23] == 8'hFF) begin
            spec_res = op_a;
        end else if (op_b[30:23] == 8'hFF) begin
            spec_res = op_b;
        end else begin
            spec_res = '0;
            spec     = 1'b0;
        end
        big    = (op_a[30:0] < op_b[30:0]) ? op_b : op_a;
        little = (op_a[30:0] < op_b[30:0]) ? op_a : op_b;
        ea     = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eb     = (little[30:23] == 8'd0) ? 8'd1 : little[30:23];
    end

    // Alignment shifter, adder input and rounding.
    always_comb begin
        b_ext = {r_mb, 3'b000};
        b_shf = b_ext >> r_d[4:0];
        b_msk = (27'd1 << r_d[4:0]) - 27'd1;
        a_ext = {1'b0, r_ma, 3'b000};
        e_field  = r_sum[26] ? r_exp : 8'd0;
        rnd_inc  = r_sum[2] && (r_sum[1] || r_sum[0] || r_sum[3]);
        rnd_comb = {1'b0, e_field, r_sum[25:3]} + {31'd0, rnd_inc};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbrd_pkg::S_IDLE: begin
                if (is_emit && r_idx < r_len) begin
                    n_state = fbrd_pkg::S_HDR;
                end
            end
            fbrd_pkg::S_HDR: begin
                if (r_step == 3'd6) begin
                    n_state = (hdr_copy < hdr_n) ? fbrd_pkg::S_RES : fbrd_pkg::S_ADD;
                end
            end
            fbrd_pkg::S_RES:  n_state = fbrd_pkg::S_RESD;
            fbrd_pkg::S_RESD: begin
                n_state = (({1'b0, r_byte} + 3'd1) == (3'd4 - r_copy))
                        ? fbrd_pkg::S_ADD : fbrd_pkg::S_RES;
            end
            fbrd_pkg::S_ADD:   n_state = spec ? fbrd_pkg::S_DONE : fbrd_pkg::S_ALIGN;
            fbrd_pkg::S_ALIGN: n_state = fbrd_pkg::S_SUM;
            fbrd_pkg::S_SUM:   n_state = fbrd_pkg::S_NORM;
            fbrd_pkg::S_NORM: begin
                if (r_sum[27] || r_sum == '0 || r_sum[26] || r_exp <= 8'd1) begin
                    n_state = fbrd_pkg::S_RND;
                end
            end
            fbrd_pkg::S_RND:  n_state = fbrd_pkg::S_DONE;
            fbrd_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = fbrd_pkg::S_IDLE;
                end
            end
            default: n_state = fbrd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbrd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_idx    <= '0;
            r_len    <= '0;
            r_prev   <= '0;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == fbrd_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                fbrd_pkg::S_IDLE: begin
                    r_step <= '0;
                    if (is_load) begin
                        r_wp <= wr_next;
                        if (i_in.start_req) begin
                            r_len  <= len_sat;
                            r_idx  <= '0;
                            r_prev <= '0;
                            r_rp   <= rp_init[AW-1:0];
                        end
                    end
                end
                fbrd_pkg::S_HDR: begin
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_req        <= r_rdata;
                        3'd2: r_med[7:0]   <= r_rdata;
                        3'd3: r_med[15:8]  <= r_rdata;
                        3'd4: r_med[23:16] <= r_rdata;
                        3'd5: r_med[31:24] <= r_rdata;
                        3'd6: begin
                            r_shift <= hdr_shift;
                            r_copy  <= hdr_copy;
                            r_byte  <= 2'(3'd4 - hdr_n);
                            r_word  <= r_prev & copy_mask;
                        end
                        default: ;
                    endcase
                end
                fbrd_pkg::S_RES: begin
                    r_rp <= rp_next;
                end
                fbrd_pkg::S_RESD: begin
                    r_word <= r_word | ({24'd0, r_rdata} << {r_byte, 3'b000});
                    r_byte <= r_byte + 2'd1;
                end
                fbrd_pkg::S_ADD: begin
                    r_prev <= 32'($signed(wsh) >>> r_shift);
                    r_res  <= spec_res;
                    r_sgn  <= big[31];
                    r_sub  <= big[31] ^ little[31];
                    r_exp  <= ea;
                    r_d    <= ea - eb;
                    r_ma   <= {big[30:23] != 8'd0, big[22:0]};
                    r_mb   <= {little[30:23] != 8'd0, little[22:0]};
                end
                fbrd_pkg::S_ALIGN: begin
                    if (r_d >= 8'd27) begin
                        r_bal <= {27'd0, r_mb != '0};
                    end else begin
                        r_bal <= {1'b0, b_shf[26:1], b_shf[0] | ((b_ext & b_msk) != '0)};
                    end
                end
                fbrd_pkg::S_SUM: begin
                    r_sum <= r_sub ? a_ext - r_bal : a_ext + r_bal;
                    if (r_sub && a_ext == r_bal) begin
                        r_sgn <= 1'b0;
                    end
                end
                fbrd_pkg::S_NORM: begin
                    if (r_sum[27]) begin
                        r_sum <= {1'b0, r_sum[27:2], r_sum[1] | r_sum[0]};
                        r_exp <= r_exp + 8'd1;
                    end else if (r_sum != '0 && !r_sum[26] && r_exp > 8'd1) begin
                        r_sum <= {r_sum[26:0], 1'b0};
                        r_exp <= r_exp - 8'd1;
                    end
                end
                fbrd_pkg::S_RND: begin
                    if (rnd_comb[30:23] == 8'hFF) begin
                        r_res <= {r_sgn, 8'hFF, 23'd0};
                    end else begin
                        r_res <= {r_sgn, rnd_comb[30:0]};
                    end
                end
                fbrd_pkg::S_DONE: begin
                    if (out_free) begin
                        r_oval   <= r_res;
                        r_olast  <= (r_idx + 8'd1) == r_len;
                        r_idx    <= r_idx + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* src/fbrd_checker.sv */
// ----------------------------------------------------------------------------
// Block float residual decoder port checker
// Watches the request and result channels of the decoder over time.
// ----------------------------------------------------------------------------
`include "float_block_residual_decoder_unit_assert.svh"

module fbrd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_req_type,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic        i_out_last
);

    `FBRD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value) && $stable(i_out_last), "result changed while stalled")
    `FBRD_ASSERT_NXT(a_load_ready, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_req_type == fbrd_pkg::REQ_LOAD), i_in_ready, "busy after a load transfer")
    `FBRD_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(i_out_valid), $past(!i_in_ready), "result without a decode")

endmodule

bind float_block_residual_decoder_unit fbrd_checker u_fbrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_req_type (i_in.req_type),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_value   (o_out.value_bits),
    .i_out_last    (o_out.last)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the block float residual decoder
// Loads compressed blocks byte by byte, requests their elements, and checks
// every decoded value against an in-bench decoder that uses integer-exact
// single-precision addition. A directed table opens the run and random
// blocks with random handshake gaps follow.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned STORE_N  = 1024;
    localparam int unsigned LEN_MAX  = 128;
    localparam int unsigned N_RANDOM = 820;
    localparam bit          REQ_LOAD = fbrd_pkg::REQ_LOAD;
    localparam bit          REQ_EMIT = fbrd_pkg::REQ_EMIT;

    typedef struct {
        bit          req;
        bit          start;
        logic [7:0]  len;
        logic [7:0]  data;
        bit          typed;
        logic [31:0] bits;
        bit          last;
    } t_row;

    typedef struct {
        logic [31:0] bits;
        logic        last;
    } t_value;

    logic i_clk;
    logic i_rst_n;

    fbrd_in_if  in_ch();
    fbrd_out_if out_ch();

    float_block_residual_decoder_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    logic [7:0]  mem_img [STORE_N];
    int unsigned wr_ptr;
    int unsigned res_ptr;
    int unsigned elem_idx;
    int unsigned blk_len;
    logic [31:0] prev_word;

    t_value      pending_values[$];
    int unsigned n_fail;
    int unsigned n_values;
    int unsigned n_items;
    bit          quiet;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("[float_block_residual_decoder_unit] ERROR");
        $finish;
    end

    function automatic logic [31:0] float_sum(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y, t;
        logic [27:0] mx, my, m;
        logic [23:0] mant;
        int          ex, ey, d, e;
        logic [2:0]  grs;
        x = a;
        y = b;
        if (x[30:23] == 8'hFF && x[22:0] != 0) return x | fbrd_pkg::QUIET_BIT;
        if (y[30:23] == 8'hFF && y[22:0] != 0) return y | fbrd_pkg::QUIET_BIT;
        if (x[30:0] == 31'h7F80_0000 && y[30:0] == 31'h7F80_0000)
            return (x[31] == y[31]) ? x : fbrd_pkg::QNAN_BITS;
        if (x[30:0] == 31'h7F80_0000) return x;
        if (y[30:0] == 31'h7F80_0000) return y;
        if (x[30:0] == 0 && y[30:0] == 0) return {x[31] & y[31], 31'h0};
        if (y[30:0] > x[30:0]) begin
            t = x;
            x = y;
            y = t;
        end
        ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        mx = {1'b0, (x[30:23] != 0), x[22:0], 3'b000};
        my = {1'b0, (y[30:23] != 0), y[22:0], 3'b000};
        d = ex - ey;
        if (d >= 27) my = (my != 0) ? 28'd1 : 28'd0;
        else if (d > 0) my = (my >> d) | ((my & ((28'd1 << d) - 1)) != 0);
        m = (x[31] == y[31]) ? mx + my : mx - my;
        if (m == 0) return 32'h0;
        e = ex;
        if (m[27]) begin
            m = (m >> 1) | m[0];
            e++;
        end else begin
            while (!m[26] && e > 1) begin
                m = m << 1;
                e--;
            end
        end
        grs = m[2:0];
        mant = m[26:3];
        if (grs > 3'd4 || (grs == 3'd4 && mant[0])) begin
            if (mant == 24'hFF_FFFF) begin
                mant = 24'h80_0000;
                e++;
            end else begin
                mant = mant + 1;
            end
        end
        if (e >= 255) return {x[31], 31'h7F80_0000};
        return {x[31], (mant[23] ? 8'(e) : 8'd0), mant[22:0]};
    endfunction

    task automatic decoder_accept(input bit req, input bit start, input logic [7:0] len,
                                  input logic [7:0] data);
        int unsigned rbits, nb, sh, lead, cp, l;
        logic [31:0] med, word, sum;
        if (req == REQ_LOAD) begin
            if (start) begin
                l = (len > LEN_MAX) ? LEN_MAX : len;
                blk_len = l;
                elem_idx = 0;
                prev_word = '0;
                wr_ptr = 0;
                res_ptr = (fbrd_pkg::HEADER_BYTES + (l + 3) / 4) % STORE_N;
            end
            mem_img[wr_ptr] = data;
            wr_ptr = (wr_ptr + 1) % STORE_N;
            return;
        end
        if (elem_idx >= blk_len) return;
        rbits = mem_img[0];
        nb = rbits / fbrd_pkg::BYTE_BITS;
        sh = 0;
        if (rbits % fbrd_pkg::BYTE_BITS != 0) begin
            sh = fbrd_pkg::BYTE_BITS - rbits % fbrd_pkg::BYTE_BITS;
            nb++;
        end
        if (nb < 1 || nb > 3) nb = 4;
        med = {mem_img[4], mem_img[3], mem_img[2], mem_img[1]};
        lead = (mem_img[(fbrd_pkg::HEADER_BYTES + (elem_idx >> 2)) % STORE_N]
                >> (6 - ((elem_idx & 3) << 1))) & fbrd_pkg::LEAD_MASK;
        cp = (lead < nb) ? lead : nb;
        word = '0;
        for (int unsigned k = 4 - nb; k < 4 - cp; k++) begin
            word[8*k +: 8] = mem_img[res_ptr];
            res_ptr = (res_ptr + 1) % STORE_N;
        end
        for (int unsigned k = 4 - cp; k < 4; k++) word[8*k +: 8] = prev_word[8*k +: 8];
        word = word << sh;
        sum = float_sum(word, med);
        prev_word = $signed(word) >>> sh;
        pending_values.push_back('{sum, (elem_idx + 1 == blk_len)});
        elem_idx++;
    endtask

    task automatic send(input bit req, input bit start, input logic [7:0] len,
                        input logic [7:0] data);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.req_type  = req;
        in_ch.start_req = start;
        in_ch.block_len = len;
        in_ch.data_byte = data;
        do @(posedge i_clk); while (!in_ch.ready);
        decoder_accept(req, start, len, data);
        n_items++;
    endtask

    always @(posedge i_clk) begin
        t_value want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_values++;
            if (pending_values.size() == 0) begin
                $display("%0t: unexpected value %h last %b", $time, out_ch.value_bits,
                         out_ch.last);
                n_fail++;
            end else begin
                want = pending_values.pop_front();
                if (out_ch.value_bits !== want.bits) begin
                    $display("%0t: value_bits expected %h actual %h", $time, want.bits,
                             out_ch.value_bits);
                    n_fail++;
                end
                if (out_ch.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last,
                             out_ch.last);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        out_ch.ready = 1'b1;
        @(negedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                out_ch.ready = 1'b1;
            end
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    end

    function automatic logic [7:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) return 8'd0;
        if (r < 9) return 8'($urandom_range(129, 255));
        if (r < 12) return 8'($urandom_range(120, 128));
        return 8'($urandom_range(1, 8));
    endfunction

    function automatic logic [7:0] pick_rbits();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'($urandom);
        if (r == 1) return 8'd0;
        return 8'($urandom_range(1, 32));
    endfunction

    function automatic logic [31:0] pick_median();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
            2: return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
            3: return {1'($urandom), 8'($urandom_range(253, 255)), 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(60, 140)), 23'h0};
        endcase
    endfunction

    task automatic send_block(input logic [7:0] len, input int unsigned fill);
        logic [31:0] med;
        int unsigned l, extra;
        l = (len > LEN_MAX) ? LEN_MAX : len;
        med = pick_median();
        send(REQ_LOAD, 1'b1, len, pick_rbits());
        for (int k = 0; k < 4; k++) send(REQ_LOAD, 1'b0, 8'($urandom), med[8*k +: 8]);
        for (int unsigned k = 0; k < (l + 3) / 4; k++)
            send(REQ_LOAD, 1'b0, 8'($urandom), 8'($urandom));
        for (int unsigned k = 0; k < 4 * l + fill; k++)
            send(REQ_LOAD, 1'b0, 8'($urandom), 8'($urandom));
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        if (l > 0 && $urandom_range(0, 9) == 0) l = $urandom_range(0, l - 1);
        for (int unsigned k = 0; k < l + extra; k++) begin
            send(REQ_EMIT, 1'($urandom), 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 15) == 0) send(REQ_LOAD, 1'b0, 8'($urandom), 8'($urandom));
        end
    endtask

    t_row rows[] = '{
        '{REQ_EMIT, 1'b0, 8'd1,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b1, 8'd2,   8'd0,  1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h80, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h3F, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'hF0, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_EMIT, 1'b0, 8'd0,   8'h00, 1'b1, 32'h3F80_0000, 1'b0},
        '{REQ_EMIT, 1'b0, 8'd255, 8'hFF, 1'b1, 32'h3F80_0000, 1'b1},
        '{REQ_EMIT, 1'b0, 8'd0,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_EMIT, 1'b1, 8'd4,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b1, 8'd0,   8'hFF, 1'b0, 32'h0,         1'b0},
        '{REQ_EMIT, 1'b0, 8'd0,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b1, 8'd1,   8'd9,  1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'hFF, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'hFF, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h7F, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h7F, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'h00, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'hFF, 1'b0, 32'h0,         1'b0},
        '{REQ_LOAD, 1'b0, 8'd0,   8'hFF, 1'b0, 32'h0,         1'b0},
        '{REQ_EMIT, 1'b0, 8'd0,   8'h00, 1'b1, 32'hFF80_0000, 1'b1}
    };

    initial begin
        int unsigned random_start;
        int unsigned blk_eff;
        logic [7:0]  blk;
        n_fail = 0;
        n_values = 0;
        n_items = 0;
        quiet = 1'b0;
        wr_ptr = 0;
        res_ptr = 0;
        elem_idx = 0;
        blk_len = 0;
        prev_word = '0;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_LOAD;
        in_ch.start_req = 1'b0;
        in_ch.block_len = '0;
        in_ch.data_byte = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[r]) begin
            send(rows[r].req, rows[r].start, rows[r].len, rows[r].data);
            if (rows[r].typed) begin
                if (pending_values.size() == 0) begin
                    $display("%0t: row %0d expected %h/%b actual none", $time, r,
                             rows[r].bits, rows[r].last);
                    n_fail++;
                end else if (pending_values[$].bits !== rows[r].bits ||
                             pending_values[$].last !== rows[r].last) begin
                    $display("%0t: row %0d expected %h/%b actual %h/%b", $time, r,
                             rows[r].bits, rows[r].last, pending_values[$].bits,
                             pending_values[$].last);
                    n_fail++;
                end
            end
        end

        // A full-length block with a saturated length, then a drain of all results.
        random_start = n_items;
        send_block(8'd200, 2);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_values.size() != 0) @(negedge i_clk);

        while (n_items - random_start < N_RANDOM) begin
            if (n_items - random_start > N_RANDOM - 100) quiet = 1'b1;
            if ($urandom_range(0, 19) == 0) begin
                send(REQ_EMIT, 1'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                blk = pick_len();
                blk_eff = (blk > LEN_MAX) ? LEN_MAX : blk;
                if (n_items - random_start + 5 * blk_eff + 60 > N_RANDOM)
                    blk = 8'($urandom_range(0, 8));
                send_block(blk, $urandom_range(0, 3));
            end
            if ($urandom_range(0, 9) == 0) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                while (pending_values.size() != 0) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Sent %0d load and emit transfers over directed and random blocks;",
                 n_items);
        $display("checked %0d decoded values with %0d mismatches.", n_values, n_fail);
        if (n_fail == 0 && pending_values.size() == 0) begin
            $display("[float_block_residual_decoder_unit] OK");
        end else begin
            $display("[float_block_residual_decoder_unit] ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+src
src/fbrd_pkg.sv
src/fbrd_in_if.sv
src/fbrd_out_if.sv
src/float_block_residual_decoder_unit.sv
src/fbrd_checker.sv
tb/sv/tb.sv
